@@ src/frp_pkg.sv @@
// ----------------------------------------------------------------------------
// frp_pkg
// Shared types and constants for the framed packet receiver.
// ----------------------------------------------------------------------------
package frp_pkg;

  localparam logic [7:0] HEADER_BYTE  = 8'hAA;
  localparam logic [7:0] LENGTH_LIMIT = 8'd250;

  localparam logic [7:0] OWN_ADDR_RESET   = 8'h00;
  localparam logic [7:0] BCAST_ADDR_RESET = 8'hFF;

  // configuration register indexes
  localparam logic CFG_OWN_ADDRESS       = 1'b0;
  localparam logic CFG_BROADCAST_ADDRESS = 1'b1;

  // one result word
  typedef struct packed {
    logic       is_verdict;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_id;
    logic [7:0] payload_length;
    logic       checksum_ok;
    logic [7:0] sum_first;
    logic [7:0] sum_second;
  } result_t;

endpackage

@@ src/frp_parser.sv @@
// ----------------------------------------------------------------------------
// frp_parser
// Frame parse state, running sums and result formation for one byte.
// ----------------------------------------------------------------------------
module frp_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [7:0]       rx_byte,
  input  logic [7:0]       own_address,
  input  logic [7:0]       broadcast_address,
  output logic             res_valid,
  output frp_pkg::result_t res
);

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_ADDR = 3'd1,
    PH_ID   = 3'd2,
    PH_LEN  = 3'd3,
    PH_DATA = 3'd4,
    PH_CK1  = 3'd5,
    PH_CK2  = 3'd6
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] remaining, remaining_next;
  logic [7:0] position, position_next;
  logic [7:0] frame_id, frame_id_next;
  logic [7:0] length, length_next;
  logic [7:0] sum1, sum1_next;
  logic [7:0] sum2, sum2_next;
  logic [7:0] check1, check1_next;

  logic [7:0] abs_sum1;
  logic [7:0] abs_sum2;
  logic [7:0] hdr_sum2;

  // sums after absorbing the current byte
  assign abs_sum1 = 8'(sum1 + rx_byte);
  assign abs_sum2 = 8'(sum2 + abs_sum1);
  // header byte restarts both sums from zero
  assign hdr_sum2 = rx_byte;

  always_comb begin
    phase_next     = phase;
    remaining_next = remaining;
    position_next  = position;
    frame_id_next  = frame_id;
    length_next    = length;
    sum1_next      = sum1;
    sum2_next      = sum2;
    check1_next    = check1;
    res_valid      = 1'b0;
    res.is_verdict     = 1'b0;
    res.payload_byte   = 8'd0;
    res.payload_index  = 8'd0;
    res.frame_id       = frame_id;
    res.payload_length = length;
    res.checksum_ok    = 1'b0;
    res.sum_first      = sum1;
    res.sum_second     = sum2;
    case (phase)
      PH_HUNT: begin
        if (rx_byte == frp_pkg::HEADER_BYTE) begin
          sum1_next  = rx_byte;
          sum2_next  = hdr_sum2;
          phase_next = PH_ADDR;
        end
      end
      PH_ADDR: begin
        if (rx_byte == own_address || rx_byte == broadcast_address) begin
          sum1_next  = abs_sum1;
          sum2_next  = abs_sum2;
          phase_next = PH_ID;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_ID: begin
        frame_id_next = rx_byte;
        sum1_next     = abs_sum1;
        sum2_next     = abs_sum2;
        phase_next    = PH_LEN;
      end
      PH_LEN: begin
        if (rx_byte < frp_pkg::LENGTH_LIMIT) begin
          length_next    = rx_byte;
          remaining_next = rx_byte;
          position_next  = 8'd0;
          sum1_next      = abs_sum1;
          sum2_next      = abs_sum2;
          // empty payload skips straight to the check bytes
          phase_next     = (rx_byte == 8'd0) ? PH_CK1 : PH_DATA;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_DATA: begin
        if (remaining == 8'd0) begin
          phase_next = PH_HUNT;
        end else begin
          sum1_next          = abs_sum1;
          sum2_next          = abs_sum2;
          position_next      = 8'(position + 8'd1);
          remaining_next     = 8'(remaining - 8'd1);
          phase_next         = (remaining == 8'd1) ? PH_CK1 : PH_DATA;
          res_valid          = 1'b1;
          res.payload_byte   = rx_byte;
          res.payload_index  = position;
          res.sum_first      = abs_sum1;
          res.sum_second     = abs_sum2;
        end
      end
      PH_CK1: begin
        check1_next = rx_byte;
        phase_next  = PH_CK2;
      end
      PH_CK2: begin
        phase_next      = PH_HUNT;
        res_valid       = 1'b1;
        res.is_verdict  = 1'b1;
        res.checksum_ok = (check1 == sum1) && (rx_byte == sum2);
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HUNT;
      remaining <= 8'd0;
      position  <= 8'd0;
      frame_id  <= 8'd0;
      length    <= 8'd0;
      sum1      <= 8'd0;
      sum2      <= 8'd0;
      check1    <= 8'd0;
    end else if (fire) begin
      phase     <= phase_next;
      remaining <= remaining_next;
      position  <= position_next;
      frame_id  <= frame_id_next;
      length    <= length_next;
      sum1      <= sum1_next;
      sum2      <= sum2_next;
      check1    <= check1_next;
    end
  end

endmodule

@@ src/frp_out_reg.sv @@
// ----------------------------------------------------------------------------
// frp_out_reg
// Result register on the output channel.
// ----------------------------------------------------------------------------
module frp_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic             load_valid,
  input  frp_pkg::result_t load_res,
  input  logic             res_stall,
  output logic             res_valid,
  output frp_pkg::result_t res
);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= load_valid;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      res <= load_res;
    end
  end

endmodule

@@ src/framed_packet_receiver.sv @@
// ----------------------------------------------------------------------------
// framed_packet_receiver
// Byte-serial frame parser with header, address, id, length and two-byte
// running-sum check; emits each payload byte and an end-of-frame verdict.
// ----------------------------------------------------------------------------
// Takes one byte per clock while rx_stall is low: each accepted rx word
// is registered in an input register, then the parse step updates the
// frame state and, for a payload byte or the second check byte, loads the
// result register that drives res_valid. rx_stall rises only while a byte
// waits in the input register behind a result that res_stall holds.
// own_address and broadcast_address are checked on the address byte of
// each frame.
module framed_packet_receiver (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic       is_verdict,
  output logic [7:0] payload_byte,
  output logic [7:0] payload_index,
  output logic [7:0] frame_id,
  output logic [7:0] payload_length,
  output logic       checksum_ok,
  output logic [7:0] sum_first,
  output logic [7:0] sum_second
);

  logic [7:0] own_address;
  logic [7:0] broadcast_address;

  logic       byte_valid;
  logic [7:0] byte_hold;
  logic       fire;

  logic             step_valid;
  frp_pkg::result_t step_res;
  frp_pkg::result_t out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address       <= frp_pkg::OWN_ADDR_RESET;
      broadcast_address <= frp_pkg::BCAST_ADDR_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        frp_pkg::CFG_OWN_ADDRESS:       own_address       <= cfg_data;
        frp_pkg::CFG_BROADCAST_ADDRESS: broadcast_address <= cfg_data;
        default: ;
      endcase
    end
  end

  // parse step runs when the result register can take its output
  assign fire     = byte_valid && (!res_valid || !res_stall);
  assign rx_stall = byte_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!rx_stall) begin
      byte_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && !rx_stall) begin
      byte_hold <= rx_byte;
    end
  end

  frp_parser u_parser (
    .clk               (clk),
    .rst               (rst),
    .fire              (fire),
    .rx_byte           (byte_hold),
    .own_address       (own_address),
    .broadcast_address (broadcast_address),
    .res_valid         (step_valid),
    .res               (step_res)
  );

  frp_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (fire),
    .load_valid (step_valid),
    .load_res   (step_res),
    .res_stall  (res_stall),
    .res_valid  (res_valid),
    .res        (out_res)
  );

  assign is_verdict     = out_res.is_verdict;
  assign payload_byte   = out_res.payload_byte;
  assign payload_index  = out_res.payload_index;
  assign frame_id       = out_res.frame_id;
  assign payload_length = out_res.payload_length;
  assign checksum_ok    = out_res.checksum_ok;
  assign sum_first      = out_res.sum_first;
  assign sum_second     = out_res.sum_second;

endmodule
